@@ hdl/sqd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared types and constants for the shortest-queue dispatcher.
// ----------------------------------------------------------------------------
package sqd_pkg;

  localparam int SERVERS_DEF   = 20;
  localparam int QUEUE_MAX_DEF = 255;

  // fixed field widths
  localparam int MASK_BITS = 20;
  localparam int IDX_W     = 5;
  localparam int BUSY_W    = 6;   // holds up to 32 servers
  localparam int TOK_CNT_W = 16;  // holds up to the largest queue limit
  localparam int WSUM_W    = 21;  // 32 x 65535 fits
  localparam int BUSY_OUT_W = 5;
  localparam int WAIT_OUT_W = 13;
  localparam int BUSY_SAT  = 31;
  localparam int WAIT_SAT  = 8191;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 48;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_SERVICE = 1'b1;

  // running result handed from cell to cell
  typedef struct packed {
    logic [TOK_CNT_W-1:0] best_cnt;
    logic [IDX_W-1:0]     best_idx;
    logic [BUSY_W-1:0]    busy_sum;
    logic [WSUM_W-1:0]    wait_sum;
    logic [MASK_BITS-1:0] started;
  } sqd_tok_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic step;
    logic kind;
    logic dep;
    logic inc;
  } sqd_ctl_t;

endpackage

@@ hdl/sqd_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd_cell
// One server: waiting count and busy flag, folds itself into the passing token.
// ----------------------------------------------------------------------------
module sqd_cell #(
  parameter int IDX       = 0,
  parameter int QUEUE_MAX = sqd_pkg::QUEUE_MAX_DEF,
  parameter int CNT_W     = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  sqd_pkg::sqd_ctl_t ctl,
  input  sqd_pkg::sqd_tok_t tok_in,
  output sqd_pkg::sqd_tok_t tok_out
);
  import sqd_pkg::*;

  localparam logic [MASK_BITS-1:0] MY_BIT =
    (IDX < MASK_BITS) ? (MASK_BITS'(1) << IDX) : '0;

  logic [CNT_W-1:0] cnt, cnt_next;
  logic             busy, busy_next;
  sqd_tok_t         tok_next;

  always_comb begin
    cnt_next  = cnt;
    busy_next = busy;
    tok_next  = tok_in;
    if (ctl.inc) begin
      cnt_next = cnt + 1'b1;
    end
    if (ctl.step && ctl.kind == KIND_SERVICE) begin
      if (!busy && cnt != '0) begin
        busy_next        = 1'b1;
        cnt_next         = cnt - 1'b1;
        tok_next.started = tok_in.started | MY_BIT;
      end else if (busy && ctl.dep) begin
        busy_next = 1'b0;
      end
    end
    // strict compare keeps the lower index on ties
    if (ctl.kind == KIND_ARRIVAL && TOK_CNT_W'(cnt) < tok_in.best_cnt) begin
      tok_next.best_cnt = TOK_CNT_W'(cnt);
      tok_next.best_idx = IDX_W'(IDX);
    end
    tok_next.busy_sum = tok_in.busy_sum + BUSY_W'(busy_next);
    tok_next.wait_sum = tok_in.wait_sum + WSUM_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      busy <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      tok_out <= tok_next;
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    TOK_CNT_W'(cnt) <= TOK_CNT_W'(QUEUE_MAX))
    else $error("waiting count above limit");
  a_no_inc_on_step: assert property (@(posedge clk) disable iff (rst)
    !(ctl.inc && ctl.step))
    else $error("increment during scan");
  a_start_takes_job: assert property (@(posedge clk) disable iff (rst)
    (ctl.step && ctl.kind == KIND_SERVICE && !busy && cnt != '0)
      |=> busy && cnt == $past(cnt) - 1'b1)
    else $error("start did not take a job");
`endif

endmodule

@@ hdl/shortest_queue_dispatcher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_queue_dispatcher_unit
// Join-shortest-queue dispatcher over a row of server cells.
// ----------------------------------------------------------------------------
// Input channel s_*: one word per item; tuser bit 0 is the kind (arrival or
// service slot), tdata holds the departure mask. Output channel m_*: one word
// per item with the chosen server, drop flag, started mask, busy count and
// total waiting count.
// A token walks the row of SERVERS cells, one cell a cycle: on an arrival it
// collects the shortest queue and the sums, on a service slot each cell
// updates itself as the token passes. The finish state then commits the
// arrival and loads the output register. A new item is taken only in the
// idle state, once the previous item has left the finish state.
// Reset empties all queues, idles all servers and drops any pending result.
// While the receiver stalls the result is held; the next item is still
// accepted and scanned, and waits in its finish state until the output
// register is free.
// ----------------------------------------------------------------------------
module shortest_queue_dispatcher_unit #(
  parameter int SERVERS   = sqd_pkg::SERVERS_DEF,
  parameter int QUEUE_MAX = sqd_pkg::QUEUE_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sqd_pkg::S_DATA_W-1:0]  s_tdata,  // [19:0] departure_mask, pad
  input  logic [0:0]                    s_tuser,  // [0] kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sqd_pkg::M_DATA_W-1:0]  m_tdata   // [4:0] chosen_server,
                                                  // [5] arrival_dropped,
                                                  // [25:6] started_mask,
                                                  // [30:26] busy_count,
                                                  // [43:31] total_waiting, pad
);
  import sqd_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_MAX + 1);
  localparam int POS_W = $clog2(SERVERS);
  localparam logic [POS_W-1:0] LAST = POS_W'(SERVERS - 1);

  typedef enum logic [1:0] {IDLE, SCAN, FIN} state_t;

  state_t               state;
  logic [POS_W-1:0]     pos;
  logic                 kind_r;
  logic [MASK_BITS-1:0] dmask;

  logic [IDX_W-1:0]      out_chosen;
  logic                  out_dropped;
  logic [MASK_BITS-1:0]  out_started;
  logic [BUSY_OUT_W-1:0] out_busy;
  logic [WAIT_OUT_W-1:0] out_total;

  sqd_tok_t link [SERVERS+1];
  sqd_tok_t fin;
  sqd_ctl_t ctl [SERVERS];

  logic              dropped;
  logic              out_free;
  logic              commit;
  logic [WSUM_W-1:0] total_sum;

  assign fin      = link[SERVERS];
  assign dropped  = (fin.best_cnt >= TOK_CNT_W'(QUEUE_MAX));
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == FIN) && out_free;
  assign total_sum = fin.wait_sum +
    WSUM_W'((kind_r == KIND_ARRIVAL) && !dropped);

  assign s_tready = (state == IDLE);

  // token entering the first cell: a queue already at the limit never wins
  assign link[0] = '{best_cnt: TOK_CNT_W'(QUEUE_MAX), best_idx: '0,
                     busy_sum: '0, wait_sum: '0, started: '0};

  for (genvar k = 0; k < SERVERS; k++) begin : g_cell
    assign ctl[k].step = (state == SCAN) && (pos == POS_W'(k));
    assign ctl[k].kind = kind_r;
    if (k < MASK_BITS) begin : g_dep
      assign ctl[k].dep = dmask[k];
    end else begin : g_nodep
      assign ctl[k].dep = 1'b0;
    end
    assign ctl[k].inc = commit && (kind_r == KIND_ARRIVAL) && !dropped &&
                        (fin.best_idx == IDX_W'(k));

    sqd_cell #(
      .IDX       (k),
      .QUEUE_MAX (QUEUE_MAX),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl[k]),
      .tok_in  (link[k]),
      .tok_out (link[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a new word replaces the old one when the register is free
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            kind_r <= s_tuser[0];
            dmask  <= s_tdata[MASK_BITS-1:0];
            pos    <= '0;
            state  <= SCAN;
          end
        end
        SCAN: begin
          if (pos == LAST) begin
            state <= FIN;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        FIN: begin
          if (out_free) begin
            if (kind_r == KIND_ARRIVAL) begin
              out_chosen  <= fin.best_idx;
              out_dropped <= dropped;
              out_started <= '0;
            end else begin
              out_chosen  <= '0;
              out_dropped <= 1'b0;
              out_started <= fin.started;
            end
            out_busy  <= (fin.busy_sum > BUSY_W'(BUSY_SAT)) ?
                         BUSY_OUT_W'(BUSY_SAT) : BUSY_OUT_W'(fin.busy_sum);
            out_total <= (total_sum > WSUM_W'(WAIT_SAT)) ?
                         WAIT_OUT_W'(WAIT_SAT) : WAIT_OUT_W'(total_sum);
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tdata = {4'b0, out_total, out_busy, out_started, out_dropped, out_chosen};

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LAST)
    else $error("scan position out of range");
  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN && pos == LAST) |=> state == FIN)
    else $error("scan did not finish");
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_started != '0) |-> (out_chosen == '0 && !out_dropped))
    else $error("mixed arrival and service result");
  a_busy_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> BUSY_W'(out_busy) <= BUSY_W'(SERVERS))
    else $error("busy count above server count");
`endif

endmodule
